FILE: design/psched_pkg.sv
// Package for the process scheduler: entry layout, result word, codes and FSM states.
// Used by psched_mem, psched_ctrl and process_scheduler_fifo_rr_priority_unit.
package psched_pkg;

  // Default ready queue depth.
  localparam int DEPTH_DEF = 16;
  // Width of the ready_count field in the result word.
  localparam int COUNT_W = 5;
  // Priority step taken off an entry whose slice has expired in priority mode.
  localparam logic signed [16:0] PRIO_DECAY = 17'sd2;

  // Operation codes carried in tuser.
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Policy codes.
  localparam logic [1:0] MODE_FCFS = 2'd0;
  localparam logic [1:0] MODE_RR   = 2'd1;
  localparam logic [1:0] MODE_PRIO = 2'd2;

  // Configuration register indexes.
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_SLICE  = 1'b1;

  // One ready queue entry as held in the entry memory.
  typedef struct packed {
    logic [7:0]         id;
    logic signed [15:0] prio;
    logic [15:0]        need;
    logic [15:0]        used;
    logic [7:0]         slice;
  } entry_t;

  // Result of one item, handed from the controller to the output register.
  typedef struct packed {
    logic [COUNT_W-1:0] ready_count;
    logic [7:0]         retired_id;
    logic               retired_valid;
    logic [7:0]         running_id;
    logic               running_valid;
    logic               accepted;
  } res_t;

  // Controller sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RUN_CHK,
    S_SH_RD,
    S_SH_WR,
    S_TAIL_WR,
    S_SEL,
    S_SCAN,
    S_CH_RD,
    S_CH_WR,
    S_DONE
  } state_t;

endpackage

FILE: design/psched_mem.sv
// Entry memory of the ready queue: one write port, one read port, registered read data.
// Depends on psched_pkg for entry_t.
module psched_mem #(
  parameter int DEPTH = psched_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  psched_pkg::entry_t   wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output psched_pkg::entry_t   rd_data
);
  import psched_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/psched_ctrl.sv
// Scheduler sequencer: arrival, retire, queue compaction, rotation, priority scan and charge.
// Depends on psched_pkg; drives the entry memory psched_mem through its ports.
module psched_ctrl #(
  parameter int DEPTH = psched_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                ready,
  input  logic                op,
  input  logic [7:0]          process_id,
  input  logic signed [15:0]  start_priority,
  input  logic [15:0]         run_need,
  input  logic [1:0]          policy,
  input  logic [7:0]          time_slice,
  output logic                res_valid,
  input  logic                res_free,
  output psched_pkg::res_t    res,
  output logic                mem_wr_en,
  output logic [IDX_W-1:0]    mem_wr_addr,
  output psched_pkg::entry_t  mem_wr_data,
  output logic                mem_rd_en,
  output logic [IDX_W-1:0]    mem_rd_addr,
  input  psched_pkg::entry_t  mem_rd_data
);
  import psched_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0] run_slot_r, run_slot_nxt;
  logic             has_run_r, has_run_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             rot_r, rot_nxt;
  entry_t           cur_r, cur_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;
  logic signed [15:0] best_prio_r, best_prio_nxt;
  logic [IDX_W-1:0] chosen_r, chosen_nxt;
  res_t             res_r, res_nxt;

  // Shared conditions.
  logic             has_run_eff;
  logic             retire_c, expire_c, sh_more_c, scan_more_c, full_c;
  logic             scan_take_c;
  logic [IDX_W-1:0] scan_best_c;
  logic signed [15:0] scan_prio_c;
  logic signed [16:0] decay_c;
  entry_t           charged_c;

  assign has_run_eff = has_run_r && (CNT_W'(run_slot_r) < len_r);
  assign full_c      = (len_r >= CNT_W'(DEPTH));
  assign retire_c    = (mem_rd_data.used >= mem_rd_data.need);
  assign expire_c    = (mode_r != MODE_FCFS) && (mem_rd_data.slice >= time_slice);
  assign sh_more_c   = (CNT_W'(idx_r) + CNT_W'(1)) < len_r;
  assign scan_more_c = (CNT_W'(idx_r) + CNT_W'(1)) < len_r;
  assign decay_c     = {mem_rd_data.prio[15], mem_rd_data.prio} - PRIO_DECAY;

  // Running best of the priority scan; a tie goes to the later entry.
  assign scan_take_c = (idx_r == '0) || (mem_rd_data.prio >= best_prio_r);
  assign scan_best_c = scan_take_c ? idx_r : best_r;
  assign scan_prio_c = scan_take_c ? mem_rd_data.prio : best_prio_r;

  // Chosen entry charged one tick: used always, slice only outside FCFS; both counters saturate.
  always_comb begin
    charged_c = mem_rd_data;
    if (mem_rd_data.used != 16'hFFFF) begin
      charged_c.used = mem_rd_data.used + 16'd1;
    end
    if ((mode_r != MODE_FCFS) && (mem_rd_data.slice != 8'hFF)) begin
      charged_c.slice = mem_rd_data.slice + 8'd1;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (op == OP_ARRIVE) begin
            state_nxt = S_DONE;
          end else if (has_run_eff) begin
            state_nxt = S_RUN_CHK;
          end else begin
            state_nxt = S_SEL;
          end
        end
      end
      S_RUN_CHK: begin
        if (retire_c || expire_c) begin
          state_nxt = S_SH_RD;
        end else if (mode_r != MODE_FCFS) begin
          state_nxt = S_CH_RD;
        end else begin
          state_nxt = S_SEL;
        end
      end
      S_SH_RD: begin
        if (sh_more_c) begin
          state_nxt = S_SH_WR;
        end else if (rot_r) begin
          state_nxt = S_TAIL_WR;
        end else begin
          state_nxt = S_SEL;
        end
      end
      S_SH_WR:   state_nxt = S_SH_RD;
      S_TAIL_WR: state_nxt = S_SEL;
      S_SEL: begin
        if (len_r == '0) begin
          state_nxt = S_DONE;
        end else if (mode_r == MODE_PRIO) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_CH_RD;
        end
      end
      S_SCAN: begin
        if (!scan_more_c) begin
          state_nxt = S_CH_RD;
        end
      end
      S_CH_RD: state_nxt = S_CH_WR;
      S_CH_WR: state_nxt = S_DONE;
      S_DONE: begin
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs: handshake and memory commands.
  always_comb begin
    ready       = (state_r == S_IDLE);
    res_valid   = (state_r == S_DONE);
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = charged_c;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    case (state_r)
      S_IDLE: begin
        if (start && (op == OP_ARRIVE) && !full_c) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = IDX_W'(len_r);
          mem_wr_data = '{id: process_id, prio: start_priority, need: run_need,
                          used: 16'd0, slice: 8'd0};
        end else if (start && (op == OP_TICK) && has_run_eff) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = run_slot_r;
        end
      end
      S_SH_RD: begin
        if (sh_more_c) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_r + IDX_W'(1);
        end
      end
      S_SH_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r;
        mem_wr_data = mem_rd_data;
      end
      S_TAIL_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = IDX_W'(len_r - CNT_W'(1));
        mem_wr_data = cur_r;
      end
      S_SEL: begin
        if ((len_r != '0) && (mode_r == MODE_PRIO)) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = '0;
        end
      end
      S_SCAN: begin
        if (scan_more_c) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_r + IDX_W'(1);
        end
      end
      S_CH_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = chosen_r;
      end
      S_CH_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = chosen_r;
        mem_wr_data = charged_c;
      end
      default: ;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    len_nxt       = len_r;
    run_slot_nxt  = run_slot_r;
    has_run_nxt   = has_run_r;
    mode_nxt      = mode_r;
    idx_nxt       = idx_r;
    rot_nxt       = rot_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    best_prio_nxt = best_prio_r;
    chosen_nxt    = chosen_r;
    res_nxt       = res_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt    = (policy inside {MODE_RR, MODE_PRIO}) ? policy : MODE_FCFS;
          has_run_nxt = has_run_eff;
          res_nxt     = '0;
          if ((op == OP_ARRIVE) && !full_c) begin
            len_nxt          = len_r + CNT_W'(1);
            res_nxt.accepted = 1'b1;
          end
        end
      end
      S_RUN_CHK: begin
        idx_nxt = run_slot_r;
        cur_nxt = mem_rd_data;
        if (retire_c) begin
          rot_nxt               = 1'b0;
          has_run_nxt           = 1'b0;
          res_nxt.retired_valid = 1'b1;
          res_nxt.retired_id    = mem_rd_data.id;
        end else if (expire_c) begin
          rot_nxt       = 1'b1;
          cur_nxt.slice = 8'd0;
          if (mode_r == MODE_PRIO) begin
            cur_nxt.prio = (decay_c[16] != decay_c[15]) ? 16'sh8000 : decay_c[15:0];
          end
        end else begin
          chosen_nxt = run_slot_r;
        end
      end
      S_SH_RD: begin
        if (!sh_more_c && !rot_r) begin
          len_nxt = len_r - CNT_W'(1);
        end
      end
      S_SH_WR: idx_nxt = idx_r + IDX_W'(1);
      S_SEL: begin
        idx_nxt    = '0;
        chosen_nxt = '0;
        if (len_r == '0) begin
          has_run_nxt  = 1'b0;
          run_slot_nxt = '0;
        end
      end
      S_SCAN: begin
        best_nxt      = scan_best_c;
        best_prio_nxt = scan_prio_c;
        idx_nxt       = idx_r + IDX_W'(scan_more_c);
        if (!scan_more_c) begin
          chosen_nxt = scan_best_c;
        end
      end
      S_CH_WR: begin
        run_slot_nxt          = chosen_r;
        has_run_nxt           = 1'b1;
        res_nxt.running_valid = 1'b1;
        res_nxt.running_id    = mem_rd_data.id;
      end
      default: ;
    endcase
    res_nxt.ready_count = COUNT_W'(len_nxt);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      len_r      <= '0;
      run_slot_r <= '0;
      has_run_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      run_slot_r <= run_slot_nxt;
      has_run_r  <= has_run_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    idx_r       <= idx_nxt;
    rot_r       <= rot_nxt;
    cur_r       <= cur_nxt;
    best_r      <= best_nxt;
    best_prio_r <= best_prio_nxt;
    chosen_r    <= chosen_nxt;
    res_r       <= res_nxt;
  end

  assign res = res_r;

  // The queue never holds more entries than the memory has rows.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CNT_W'(DEPTH))
    else $error("queue length above depth");

  // Reads and writes never meet at one row in one cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
    else $error("read and write to the same entry");

  // Between items the running slot lies inside the queue.
  a_run_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && has_run_r |-> CNT_W'(run_slot_r) < len_r)
    else $error("running slot outside the queue");

  // The length moves by at most one entry per cycle.
  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (len_r == $past(len_r)) || (len_r == $past(len_r) + CNT_W'(1))
                     || (len_r == $past(len_r) - CNT_W'(1)))
    else $error("queue length jumped");

endmodule

FILE: design/process_scheduler_fifo_rr_priority_unit.sv
// Top level of the process scheduler: configuration registers, output register, instances.
// Depends on psched_pkg, psched_mem and psched_ctrl.
//
//  Channel  Direction  Handshake               Word
//  in_      slave      in_tvalid / in_tready   tuser op, tdata id, priority, need
//  out_     master     out_tvalid / out_tready tdata result fields
//  cfg_     slave      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A tick does more work than an arrival: it moves up every entry behind a retired or
// rotated one, and in priority mode it scans every queue entry, as every shift and scan
// step goes through the single read port of the entry memory.
// Reset is synchronous and empties the queue at once; entry rows are not cleared.
// A finished result waits in the output register; the next word is taken only once
// it can be handed on. Configuration writes are always ready.
module process_scheduler_fifo_rr_priority_unit #(
  parameter int QUEUE_DEPTH = psched_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // process_id [7:0], start_priority [23:8], run need [39:24]
  input  logic        in_tuser,   // op [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // accepted [0], running_valid [1], running_id [9:2],
                                  // retired_valid [10], retired_id [18:11], ready_count [23:19]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import psched_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [1:0]  policy_r;
  logic [7:0]  slice_r;
  logic        out_valid_r, out_valid_nxt;
  res_t        out_res_r;

  logic        ctrl_ready, res_valid, res_free;
  res_t        res;
  logic             mem_wr_en, mem_rd_en;
  logic [IDX_W-1:0] mem_wr_addr, mem_rd_addr;
  entry_t           mem_wr_data, mem_rd_data;

  assign cfg_ready = 1'b1;
  assign in_tready = ctrl_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= MODE_FCFS;
      slice_r  <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POLICY: policy_r <= cfg_data[1:0];
        REG_SLICE:  slice_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register between the controller and the result channel.
  assign res_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_free) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

  psched_ctrl #(
    .DEPTH (QUEUE_DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (in_tvalid && in_tready),
    .ready          (ctrl_ready),
    .op             (in_tuser),
    .process_id     (in_tdata[7:0]),
    .start_priority (in_tdata[23:8]),
    .run_need       (in_tdata[39:24]),
    .policy         (policy_r),
    .time_slice     (slice_r),
    .res_valid      (res_valid),
    .res_free       (res_free),
    .res            (res),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data)
  );

  psched_mem #(
    .DEPTH (QUEUE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule
